/* sv/naalu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// naalu_pkg
// types, operation codes and the factorial table for the null-aware alu
// ----------------------------------------------------------------------------
package naalu_pkg;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_AND = 5'd5, OP_XOR = 5'd6, OP_OR = 5'd7, OP_NOT = 5'd8, OP_FACT = 5'd9,
    OP_EQ = 5'd10, OP_NE = 5'd11, OP_GT = 5'd12, OP_LT = 5'd13, OP_GE = 5'd14,
    OP_LE = 5'd15, OP_DIST = 5'd16, OP_NDIST = 5'd17
  } op_t;

  localparam int unsigned FACT_LIMIT = 20;
  localparam int unsigned DIV_STEPS  = 64;

  typedef struct packed {
    logic [4:0]         req_type;
    logic [1:0]         width_sel;
    logic signed [63:0] operand_a;
    logic               a_is_null;
    logic signed [63:0] operand_b;
    logic               b_is_null;
  } in_req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic               result_is_null;
    logic               overflow_error;
  } out_req_t;

  // classified request handed from front to back
  typedef enum logic [1:0] {
    CL_DONE = 2'd0, CL_MUL = 2'd1, CL_DIV = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic        is_mod;
    logic [1:0]  width_sel;
    logic [63:0] a;
    logic [63:0] b;
    out_req_t    res;
  } job_t;

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] w);
    logic [63:0] r;
    unique case (w)
      2'd0: r = {{56{v[7]}}, v[7:0]};
      2'd1: r = {{48{v[15]}}, v[15:0]};
      2'd2: r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] fact_lut(input logic [4:0] n);
    logic [63:0] r;
    unique case (n)
      5'd0, 5'd1: r = 64'd1;
      5'd2:  r = 64'd2;
      5'd3:  r = 64'd6;
      5'd4:  r = 64'd24;
      5'd5:  r = 64'd120;
      5'd6:  r = 64'd720;
      5'd7:  r = 64'd5040;
      5'd8:  r = 64'd40320;
      5'd9:  r = 64'd362880;
      5'd10: r = 64'd3628800;
      5'd11: r = 64'd39916800;
      5'd12: r = 64'd479001600;
      5'd13: r = 64'd6227020800;
      5'd14: r = 64'd87178291200;
      5'd15: r = 64'd1307674368000;
      5'd16: r = 64'd20922789888000;
      5'd17: r = 64'd355687428096000;
      5'd18: r = 64'd6402373705728000;
      5'd19: r = 64'd121645100408832000;
      5'd20: r = 64'd2432902008176640000;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/naalu_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// naalu_front
// accepts requests, sign-extends operands, settles every op but mul/div/mod
// ----------------------------------------------------------------------------
module naalu_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire naalu_pkg::in_req_t in_data,
  output logic                   job_valid,
  input  wire logic              job_stall,
  output naalu_pkg::job_t        job_data
);

  logic              valid_r;
  naalu_pkg::job_t   job_r, job_nxt;
  logic [63:0]       a, b;
  logic              either, lt_ab, lt_ba, eq, is_dist;
  logic [63:0]       v;
  logic              nul, err;

  assign in_stall  = valid_r && job_stall;
  assign job_valid = valid_r;
  assign job_data  = job_r;

  always_comb begin
    a      = naalu_pkg::sext(in_data.operand_a, in_data.width_sel);
    b      = naalu_pkg::sext(in_data.operand_b, in_data.width_sel);
    either = in_data.a_is_null || in_data.b_is_null;
    lt_ab  = $signed(a) < $signed(b);
    lt_ba  = $signed(b) < $signed(a);
    eq     = a == b;
    is_dist = (in_data.a_is_null || in_data.b_is_null) ?
              (in_data.a_is_null != in_data.b_is_null) : !eq;
    v = '0; nul = either; err = 1'b0;
    job_nxt.cls = naalu_pkg::CL_DONE;
    job_nxt.is_mod = 1'b0;
    unique case (in_data.req_type)
      naalu_pkg::OP_ADD: v = naalu_pkg::sext(a + b, in_data.width_sel);
      naalu_pkg::OP_SUB: v = naalu_pkg::sext(a - b, in_data.width_sel);
      naalu_pkg::OP_AND: v = a & b;
      naalu_pkg::OP_XOR: v = a ^ b;
      naalu_pkg::OP_OR:  v = a | b;
      naalu_pkg::OP_MUL: if (!either) job_nxt.cls = naalu_pkg::CL_MUL;
      naalu_pkg::OP_DIV, naalu_pkg::OP_MOD: begin
        nul = either || (b == 64'd0);
        job_nxt.is_mod = in_data.req_type == naalu_pkg::OP_MOD;
        if (!nul) job_nxt.cls = naalu_pkg::CL_DIV;
      end
      naalu_pkg::OP_NOT: begin
        nul = in_data.a_is_null;
        v   = ~a;
      end
      naalu_pkg::OP_FACT: begin
        nul = in_data.a_is_null;
        if (!in_data.a_is_null && $signed(a) > $signed(64'(naalu_pkg::FACT_LIMIT))) begin
          nul = 1'b1;
          err = 1'b1;
        end else if (a[63]) begin
          v = 64'd1;
        end else begin
          v = naalu_pkg::fact_lut(a[4:0]);
        end
      end
      naalu_pkg::OP_EQ: v = {63'd0, eq};
      naalu_pkg::OP_NE: v = {63'd0, !eq};
      naalu_pkg::OP_GT: v = {63'd0, lt_ba};
      naalu_pkg::OP_LT: v = {63'd0, lt_ab};
      naalu_pkg::OP_GE: v = {63'd0, !lt_ab};
      naalu_pkg::OP_LE: v = {63'd0, !lt_ba};
      naalu_pkg::OP_DIST: begin
        nul = 1'b0;
        v   = {63'd0, is_dist};
      end
      naalu_pkg::OP_NDIST: begin
        nul = 1'b0;
        v   = {63'd0, !is_dist};
      end
      default: nul = 1'b1;
    endcase
    if (nul) job_nxt.cls = naalu_pkg::CL_DONE;
    job_nxt.width_sel          = in_data.width_sel;
    job_nxt.a                  = a;
    job_nxt.b                  = b;
    job_nxt.res.result_value   = nul ? 64'd0 : v;
    job_nxt.res.result_is_null = nul;
    job_nxt.res.overflow_error = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
    if (!in_stall && in_valid) job_r <= job_nxt;
  end

endmodule
`default_nettype wire

/* sv/naalu_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// naalu_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module naalu_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_stall,
  input  wire naalu_pkg::job_t wr_data,
  output logic                 rd_valid,
  input  wire logic            rd_stall,
  output naalu_pkg::job_t      rd_data
);

  naalu_pkg::job_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            push, pop;

  assign wr_stall = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

/* sv/naalu_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// naalu_back
// carries out multiply (three 32x32 partial products) and radix-2 divide
// ----------------------------------------------------------------------------
module naalu_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_valid,
  output logic                  job_stall,
  input  wire naalu_pkg::job_t  job_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output naalu_pkg::out_req_t   out_data
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  state_t            state_r;
  logic              ovalid_r, ovalid_nxt;
  naalu_pkg::out_req_t odata_r;
  logic [1:0]        wsel_r;
  logic              is_mod_r, neg_q_r, neg_r_r;
  logic [63:0]       ma_r, mb_r, q_r, rem_r;
  logic [6:0]        cnt_r;
  logic [63:0]       p0_r, p1_r, p2_r;
  logic              take, out_free;
  logic [64:0]       trial;
  logic [63:0]       rem_sh, q_fin, r_fin;

  assign out_free  = !ovalid_r || !out_stall;
  assign job_stall = !(state_r == S_IDLE && out_free);
  assign take      = job_valid && !job_stall;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_comb begin
    rem_sh = {rem_r[62:0], ma_r[63]};
    trial  = {1'b0, rem_sh} - {1'b0, mb_r};
    q_fin  = neg_q_r ? 64'd0 - q_r : q_r;
    r_fin  = neg_r_r ? 64'd0 - rem_r : rem_r;
    ovalid_nxt = (take && job_data.cls != naalu_pkg::CL_MUL &&
                  job_data.cls != naalu_pkg::CL_DIV) ||
                 ((state_r == S_MUL || state_r == S_FIN) && out_free) ||
                 (ovalid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      unique case (state_r)
        S_IDLE: if (take) begin
          wsel_r   <= job_data.width_sel;
          is_mod_r <= job_data.is_mod;
          unique case (job_data.cls)
            naalu_pkg::CL_MUL: begin
              p0_r    <= job_data.a[31:0] * job_data.b[31:0];
              p1_r    <= job_data.a[63:32] * job_data.b[31:0];
              p2_r    <= job_data.a[31:0] * job_data.b[63:32];
              state_r <= S_MUL;
            end
            naalu_pkg::CL_DIV: begin
              ma_r    <= job_data.a[63] ? 64'd0 - job_data.a : job_data.a;
              mb_r    <= job_data.b[63] ? 64'd0 - job_data.b : job_data.b;
              neg_q_r <= job_data.a[63] ^ job_data.b[63];
              neg_r_r <= job_data.a[63];
              rem_r   <= '0;
              q_r     <= '0;
              cnt_r   <= 7'(naalu_pkg::DIV_STEPS);
              state_r <= S_DIV;
            end
            default: begin
              odata_r  <= job_data.res;
            end
          endcase
        end
        S_MUL: if (out_free) begin
          odata_r.result_value <= naalu_pkg::sext(
            p0_r + {p1_r[31:0] + p2_r[31:0], 32'd0}, wsel_r);
          odata_r.result_is_null <= 1'b0;
          odata_r.overflow_error <= 1'b0;
          state_r  <= S_IDLE;
        end
        S_DIV: begin
          ma_r <= {ma_r[62:0], 1'b0};
          if (!trial[64]) begin
            rem_r <= trial[63:0];
            q_r   <= {q_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r   <= {q_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) state_r <= S_FIN;
        end
        S_FIN: if (out_free) begin
          odata_r.result_value   <= naalu_pkg::sext(is_mod_r ? r_fin : q_fin, wsel_r);
          odata_r.result_is_null <= 1'b0;
          odata_r.overflow_error <= 1'b0;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/null_aware_integer_alu_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// null_aware_integer_alu_unit
// sql-style integer alu with null propagation
// ----------------------------------------------------------------------------
// add, sub, logic, not, factorial and all comparisons are settled in the front
// stage and flow at one request per cycle while the back is idle and the output
// is not stalled. multiply is done in the back stage (32x32 partial products,
// then a sum); divide and modulo run in a one-bit-per-cycle restoring divider.
// a two-entry queue lets the front keep accepting while the back works.
module null_aware_integer_alu_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire naalu_pkg::in_req_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output naalu_pkg::out_req_t      out_data
);

  logic            f_valid, f_stall, q_valid, q_stall;
  naalu_pkg::job_t f_data, q_data;

  naalu_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid(f_valid), .job_stall(f_stall), .job_data(f_data)
  );

  naalu_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_data)
  );

  naalu_back u_back (
    .clk, .rst_n,
    .job_valid(q_valid), .job_stall(q_stall), .job_data(q_data),
    .out_valid, .out_stall, .out_data
  );

  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_is_null |-> out_data.result_value == 64'd0)
    else $error("null result with nonzero value");

  a_err_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow_error |-> out_data.result_is_null)
    else $error("error without null");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule
`default_nettype wire
